@@ hw/rtl/vpcp_pkg.sv @@
// Shared constants and types for the video processor CPU port.
`timescale 1ns / 1ps
package vpcp_pkg;

  localparam int ACTIVE_LINES = 192;
  localparam int MEM_DEPTH    = 16384;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);
  localparam int ADDR_W       = 14;
  localparam int LINE_W       = 9;
  localparam int TICK_W       = 10;
  localparam int CFG_W        = 10;

  localparam logic [LINE_W-1:0] LINES_RESET = 9'd262;
  localparam logic [TICK_W-1:0] TICKS_RESET = 10'd342;

  typedef enum logic [2:0] {
    ACT_CTRL_WR = 3'd0,
    ACT_DATA_WR = 3'd1,
    ACT_DATA_RD = 3'd2,
    ACT_STAT_RD = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CODE_READ_SETUP  = 2'd0,
    CODE_WRITE_SETUP = 2'd1,
    CODE_REG_WRITE   = 2'd2,
    CODE_ADDR_ONLY   = 2'd3
  } ctrl_code_t;

  typedef enum logic {
    CFG_LINES_PER_FRAME = 1'b0,
    CFG_TICKS_PER_LINE  = 1'b1
  } cfg_index_t;

  localparam logic [2:0] IRQ_REG_SEL = 3'd1;
  localparam int         IRQ_EN_BIT  = 5;

endpackage

@@ hw/rtl/video_processor_cpu_port_unit.sv @@
// Video processor CPU port: host access to VRAM and mode registers, scanline timing.
// Result words are registered; a two-entry output stage absorbs a stalled sink.
// Throughput: one word per cycle while s_tready is high (no clear, skid entry free).
// VRAM is a single-port synchronous RAM; prefetched read data is taken from its
// registered output on the next item, so back-to-back accesses need no stall.
// Reset (rst, synchronous): clears all control state, then clears VRAM one byte a
// cycle, all MEM_DEPTH (16384) bytes, with s_tready low; cfg writes are taken throughout.
`timescale 1ns / 1ps
module video_processor_cpu_port_unit
  import vpcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [2:0] action, [10:3] host_byte, rest zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [7:0] read_byte, [8] irq_level, rest zero
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // VRAM
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic              mem_rd;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  // clear pass
  logic              clearing;
  logic [MEM_AW-1:0] clr_cnt;

  // port state
  logic [ADDR_W-1:0] addr, addr_next;
  logic              second_due, second_due_next;
  logic [7:0]        first_byte, first_byte_next;
  logic [7:0]        ra_reg, ra_reg_next;
  logic              ra_pending, ra_pending_next;
  logic              frame_flag, frame_flag_next;
  logic              irq_en, irq_en_next;
  logic [LINE_W-1:0] line_num, line_num_next;
  logic [TICK_W-1:0] tick_cnt, tick_cnt_next;
  logic [LINE_W-1:0] lines_per_frame;
  logic [TICK_W-1:0] ticks_per_line;

  // output stage
  logic              sk_valid;
  logic [8:0]        out_word, sk_word, res_word;

  logic              accept;
  action_t           act;
  logic [7:0]        hb;
  logic [7:0]        ra_eff;
  logic [7:0]        rd_byte;
  logic [ADDR_W-1:0] ctrl_addr;
  logic [TICK_W:0]   tick_inc;
  logic [LINE_W:0]   line_inc;

  assign act      = action_t'(s_tdata[2:0]);
  assign hb       = s_tdata[10:3];
  assign s_tready = !clearing && !sk_valid;
  assign accept   = s_tvalid && s_tready;
  assign ra_eff   = ra_pending ? mem_q : ra_reg;
  assign ctrl_addr = {hb[5:0], first_byte};
  assign tick_inc = {1'b0, tick_cnt} + 1'b1;
  assign line_inc = {1'b0, line_num} + 1'b1;

  always_comb begin
    addr_next       = addr;
    second_due_next = second_due;
    first_byte_next = first_byte;
    ra_reg_next     = ra_reg;
    ra_pending_next = ra_pending;
    frame_flag_next = frame_flag;
    irq_en_next     = irq_en;
    line_num_next   = line_num;
    tick_cnt_next   = tick_cnt;
    rd_byte         = 8'd0;
    mem_we          = 1'b0;
    mem_rd          = 1'b0;
    mem_addr        = addr[MEM_AW-1:0];
    mem_wdata       = hb;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt;
      mem_wdata = 8'd0;
    end else if (accept) begin
      case (act)
        ACT_CTRL_WR: begin
          if (!second_due) begin
            first_byte_next = hb;
            second_due_next = 1'b1;
            addr_next       = {addr[ADDR_W-1:8], hb};
          end else begin
            second_due_next = 1'b0;
            addr_next       = ctrl_addr;
            case (ctrl_code_t'(hb[7:6]))
              CODE_READ_SETUP: begin
                mem_rd          = 1'b1;
                mem_addr        = ctrl_addr[MEM_AW-1:0];
                ra_pending_next = 1'b1;
                addr_next       = ctrl_addr + 1'b1;
              end
              CODE_REG_WRITE: begin
                if (hb[2:0] == IRQ_REG_SEL) irq_en_next = first_byte[IRQ_EN_BIT];
              end
              default: ;
            endcase
          end
        end
        ACT_DATA_WR: begin
          second_due_next = 1'b0;
          mem_we          = 1'b1;
          ra_reg_next     = hb;
          ra_pending_next = 1'b0;
          addr_next       = addr + 1'b1;
        end
        ACT_DATA_RD: begin
          second_due_next = 1'b0;
          rd_byte         = ra_eff;
          mem_rd          = 1'b1;
          ra_pending_next = 1'b1;
          addr_next       = addr + 1'b1;
        end
        ACT_STAT_RD: begin
          second_due_next = 1'b0;
          rd_byte         = {frame_flag, 7'd0};
          frame_flag_next = 1'b0;
        end
        ACT_TICK: begin
          if (tick_inc < {1'b0, ticks_per_line}) begin
            tick_cnt_next = tick_inc[TICK_W-1:0];
          end else begin
            tick_cnt_next = '0;
            if (line_num == LINE_W'(ACTIVE_LINES)) frame_flag_next = 1'b1;
            if (line_inc >= {1'b0, lines_per_frame}) line_num_next = '0;
            else line_num_next = line_inc[LINE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign res_word = {frame_flag_next && irq_en_next, rd_byte};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_rd) mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_cnt    <= '0;
      addr       <= '0;
      second_due <= 1'b0;
      first_byte <= 8'd0;
      ra_reg     <= 8'd0;
      ra_pending <= 1'b0;
      frame_flag <= 1'b0;
      irq_en     <= 1'b0;
      line_num   <= '0;
      tick_cnt   <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) clearing <= 1'b0;
      end
      addr       <= addr_next;
      second_due <= second_due_next;
      first_byte <= first_byte_next;
      ra_reg     <= ra_reg_next;
      ra_pending <= ra_pending_next;
      frame_flag <= frame_flag_next;
      irq_en     <= irq_en_next;
      line_num   <= line_num_next;
      tick_cnt   <= tick_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_per_frame <= LINES_RESET;
      ticks_per_line  <= TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LINES_PER_FRAME: lines_per_frame <= cfg_data[LINE_W-1:0];
        CFG_TICKS_PER_LINE:  ticks_per_line  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (accept) begin
      if (!m_tvalid || m_tready) begin
        out_word <= res_word;
        m_tvalid <= 1'b1;
      end else begin
        sk_word  <= res_word;
        sk_valid <= 1'b1;
      end
    end else if (m_tvalid && m_tready) begin
      if (sk_valid) begin
        out_word <= sk_word;
        sk_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {7'd0, out_word};

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("word accepted during VRAM clear");

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> m_tvalid) else $error("skid entry valid without output word");

  a_clear_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clearing && clr_cnt == '0) else $error("no clear pass after reset");

  a_pending_from_rd: assert property (@(posedge clk) disable iff (rst)
    $rose(ra_pending) |-> $past(mem_rd)) else $error("read-ahead pending without VRAM read");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    sk_valid && m_tready |=> !sk_valid) else $error("skid entry not drained");
`endif

endmodule
